@@ rtl/ets_pkg.sv @@
package ets_pkg;

	localparam int unsigned POSITION_BITS_DEF = 32;
	localparam int unsigned LENGTH_BITS_DEF = 16;
	localparam int unsigned OUT_DEPTH = 4;

	typedef enum logic [3:0] {
		KIND_VAR    = 4'd0,
		KIND_INT    = 4'd1,
		KIND_FLOAT  = 4'd2,
		KIND_PRINT  = 4'd3,
		KIND_IDENT  = 4'd4,
		KIND_NUMBER = 4'd5,
		KIND_ASSIGN = 4'd6,
		KIND_SEMI   = 4'd7,
		KIND_PLUS   = 4'd8,
		KIND_MINUS  = 4'd9,
		KIND_STAR   = 4'd10,
		KIND_SLASH  = 4'd11,
		KIND_LPAREN = 4'd12,
		KIND_RPAREN = 4'd13,
		KIND_END    = 4'd14,
		KIND_ERROR  = 4'd15
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_DOT  = 2'd1,
		ERR_UNEXPECT = 2'd2
	} err_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ASSIGN = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// first bytes of an identifier, oldest byte highest
	localparam logic [39:0] KW_VAR   = 40'h00_0076_6172;
	localparam logic [39:0] KW_INT   = 40'h00_0069_6E74;
	localparam logic [39:0] KW_FLOAT = 40'h66_6C6F_6174;
	localparam logic [39:0] KW_PRINT = 40'h70_7269_6E74;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return (c == CH_ASSIGN) || (c == CH_SEMI) || (c == CH_PLUS) || (c == CH_MINUS) ||
			(c == CH_STAR) || (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN);
	endfunction

	function automatic kind_t operator_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_ASSIGN: k = KIND_ASSIGN;
			CH_SEMI:   k = KIND_SEMI;
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			default:   k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/expression_token_scanner_unit.sv @@
// expression token scanner
// in channel: one source byte per request on char_in (in_valid / in_ready);
// byte 0 ends the source and the next byte starts a new one at offset 0
// out channel: token requests on token_kind, token_start, token_length,
// has_fraction, error_code, last_of_run (out_valid / out_ready)
// a byte gives zero, one or two tokens; last_of_run marks the final one
// tokens caused by a byte are written into the output queue register when
// the byte is taken, and reach the out side in queue order
// throughput: one byte per cycle while in_ready is high, set by the scan state update;
// a four-entry output queue holds tokens, and in_ready is high while it has
// room for two, so bytes keep flowing while the receiver takes tokens
// a stalled receiver fills the queue and then holds in_ready low
// reset: scanner idle at offset 0, output queue empty
// after an error token the scanner ignores every byte until reset
module expression_token_scanner_unit #(
	parameter int unsigned POSITION_BITS = ets_pkg::POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS = ets_pkg::LENGTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               char_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ets_pkg::kind_t           token_kind,
	output logic [POSITION_BITS-1:0] token_start,
	output logic [LENGTH_BITS-1:0]   token_length,
	output logic                     has_fraction,
	output ets_pkg::err_t            error_code,
	output logic                     last_of_run
);
	import ets_pkg::*;

	localparam int unsigned PTR_BITS = $clog2(OUT_DEPTH);
	localparam int unsigned CNT_BITS = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_DIGITS,
		MODE_DOT,
		MODE_FRAC,
		MODE_HALT
	} mode_t;

	// scan state
	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] tok_start_q, tok_start_d;
	logic [LENGTH_BITS-1:0]   tok_len_q, tok_len_d;
	logic [39:0]              prefix_q, prefix_d;

	// output queue
	kind_t                    q_kind_q  [OUT_DEPTH];
	logic [POSITION_BITS-1:0] q_start_q [OUT_DEPTH];
	logic [LENGTH_BITS-1:0]   q_len_q   [OUT_DEPTH];
	logic                     q_frac_q  [OUT_DEPTH];
	err_t                     q_err_q   [OUT_DEPTH];
	logic                     q_last_q  [OUT_DEPTH];
	logic [PTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]      count_q;

	logic in_fire, out_fire;

	// token closed by this byte, then token started by it
	logic                     close_v, new_v;
	kind_t                    close_kind, new_kind;
	logic [POSITION_BITS-1:0] close_start;
	logic [LENGTH_BITS-1:0]   close_len, new_len;
	logic                     close_frac;
	err_t                     close_err, new_err;
	logic                     go_idle;

	logic [LENGTH_BITS-1:0]   grow_len;
	logic [39:0]              grow_prefix;
	logic [POSITION_BITS-1:0] pos_next;
	kind_t                    ident_kind;

	assign in_ready  = (count_q <= CNT_BITS'(OUT_DEPTH - 2));
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign out_fire  = out_valid && out_ready;

	assign pos_next    = pos_q + POSITION_BITS'(1);
	assign grow_len    = (tok_len_q == '1) ? tok_len_q : tok_len_q + LENGTH_BITS'(1);
	// only the first five bytes feed the keyword compare
	assign grow_prefix = (tok_len_q < LENGTH_BITS'(5)) ? {prefix_q[31:0], char_in} : prefix_q;

	always_comb begin
		if ((tok_len_q == LENGTH_BITS'(3)) && (prefix_q == KW_VAR)) begin
			ident_kind = KIND_VAR;
		end else if ((tok_len_q == LENGTH_BITS'(3)) && (prefix_q == KW_INT)) begin
			ident_kind = KIND_INT;
		end else if ((tok_len_q == LENGTH_BITS'(5)) && (prefix_q == KW_FLOAT)) begin
			ident_kind = KIND_FLOAT;
		end else if ((tok_len_q == LENGTH_BITS'(5)) && (prefix_q == KW_PRINT)) begin
			ident_kind = KIND_PRINT;
		end else begin
			ident_kind = KIND_IDENT;
		end
	end

	always_comb begin
		mode_d      = mode_q;
		pos_d       = pos_q;
		tok_start_d = tok_start_q;
		tok_len_d   = tok_len_q;
		prefix_d    = prefix_q;
		close_v     = 1'b0;
		close_kind  = KIND_NUMBER;
		close_start = tok_start_q;
		close_len   = tok_len_q;
		close_frac  = 1'b0;
		close_err   = ERR_NONE;
		new_v       = 1'b0;
		new_kind    = KIND_END;
		new_len     = '0;
		new_err     = ERR_NONE;
		go_idle     = 1'b0;

		unique case (mode_q)
			MODE_HALT: begin
			end
			MODE_IDENT: begin
				if (is_letter(char_in) || is_digit(char_in)) begin
					tok_len_d = grow_len;
					prefix_d  = grow_prefix;
					pos_d     = pos_next;
				end else begin
					close_v    = 1'b1;
					close_kind = ident_kind;
					go_idle    = 1'b1;
				end
			end
			MODE_DIGITS: begin
				if (is_digit(char_in) || (char_in == CH_DOT)) begin
					tok_len_d = grow_len;
					prefix_d  = grow_prefix;
					pos_d     = pos_next;
					if (char_in == CH_DOT) begin
						mode_d = MODE_DOT;
					end
				end else begin
					close_v = 1'b1;
					go_idle = 1'b1;
				end
			end
			MODE_DOT: begin
				if (is_digit(char_in)) begin
					tok_len_d = grow_len;
					prefix_d  = grow_prefix;
					pos_d     = pos_next;
					mode_d    = MODE_FRAC;
				end else begin
					// dot without a following digit
					close_v     = 1'b1;
					close_kind  = KIND_ERROR;
					close_start = pos_q;
					close_len   = '0;
					close_err   = ERR_BAD_DOT;
					mode_d      = MODE_HALT;
				end
			end
			MODE_FRAC: begin
				if (is_digit(char_in)) begin
					tok_len_d = grow_len;
					prefix_d  = grow_prefix;
					pos_d     = pos_next;
				end else begin
					close_v    = 1'b1;
					close_frac = 1'b1;
					go_idle    = 1'b1;
				end
			end
			MODE_IDLE: begin
				go_idle = 1'b1;
			end
			default: begin
				go_idle = 1'b1;
			end
		endcase

		// byte starts something new
		if (go_idle) begin
			mode_d = MODE_IDLE;
			if (is_space(char_in)) begin
				pos_d = pos_next;
			end else if (is_digit(char_in) || is_letter(char_in)) begin
				tok_start_d = pos_q;
				tok_len_d   = LENGTH_BITS'(1);
				prefix_d    = {32'd0, char_in};
				pos_d       = pos_next;
				mode_d      = is_digit(char_in) ? MODE_DIGITS : MODE_IDENT;
			end else if (is_operator(char_in)) begin
				new_v    = 1'b1;
				new_kind = operator_kind(char_in);
				new_len  = LENGTH_BITS'(1);
				pos_d    = pos_next;
			end else if (char_in == CH_NUL) begin
				// end of source, next source starts at offset 0
				new_v       = 1'b1;
				new_kind    = KIND_END;
				pos_d       = '0;
				tok_start_d = '0;
				tok_len_d   = '0;
				prefix_d    = '0;
			end else begin
				new_v    = 1'b1;
				new_kind = KIND_ERROR;
				new_err  = ERR_UNEXPECT;
				mode_d   = MODE_HALT;
			end
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pos_q       <= '0;
			tok_start_q <= '0;
			tok_len_q   <= '0;
			prefix_q    <= '0;
		end else if (in_fire) begin
			mode_q      <= mode_d;
			pos_q       <= pos_d;
			tok_start_q <= tok_start_d;
			tok_len_q   <= tok_len_d;
			prefix_q    <= prefix_d;
		end
	end

	logic                push_close, push_new;
	logic [PTR_BITS-1:0] new_slot;
	logic [1:0]          push_n;

	assign push_close = in_fire && close_v;
	assign push_new   = in_fire && new_v;
	assign new_slot   = wr_ptr_q + PTR_BITS'(push_close);
	assign push_n     = 2'(push_close) + 2'(push_new);

	// queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (push_close) begin
			q_kind_q[wr_ptr_q]  <= close_kind;
			q_start_q[wr_ptr_q] <= close_start;
			q_len_q[wr_ptr_q]   <= close_len;
			q_frac_q[wr_ptr_q]  <= close_frac;
			q_err_q[wr_ptr_q]   <= close_err;
			q_last_q[wr_ptr_q]  <= !new_v;
		end
		if (push_new) begin
			q_kind_q[new_slot]  <= new_kind;
			q_start_q[new_slot] <= pos_q;
			q_len_q[new_slot]   <= new_len;
			q_frac_q[new_slot]  <= 1'b0;
			q_err_q[new_slot]   <= new_err;
			q_last_q[new_slot]  <= 1'b1;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
		end
	end

	assign token_kind   = q_kind_q[rd_ptr_q];
	assign token_start  = q_start_q[rd_ptr_q];
	assign token_length = q_len_q[rd_ptr_q];
	assign has_fraction = q_frac_q[rd_ptr_q];
	assign error_code   = q_err_q[rd_ptr_q];
	assign last_of_run  = q_last_q[rd_ptr_q];

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(OUT_DEPTH))
		else $error("output queue over depth");

	// a halted scanner stays halted
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_HALT) |=> (mode_q == MODE_HALT))
		else $error("scanner left halt without reset");

	// end of source returns the position to zero
	a_end_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (mode_q == MODE_IDLE) && (char_in == CH_NUL)) |=> (pos_q == '0))
		else $error("position not rewound after end");

	// halted bytes produce no tokens
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (mode_q == MODE_HALT) && !out_fire) |=> $stable(count_q))
		else $error("token produced while halted");

endmodule

@@ bench/ets_token_checker.sv @@
`timescale 1ns / 1ps
module ets_token_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [7:0]      char_in,
	input  logic            out_valid,
	input  logic            out_ready,
	input  ets_pkg::kind_t  token_kind,
	input  logic [31:0]     token_start,
	input  logic [15:0]     token_length,
	input  logic            has_fraction,
	input  ets_pkg::err_t   error_code,
	input  logic            last_of_run,
	output int              fail_count,
	output int              pending_count,
	output int              tokens_checked,
	output logic [15:0]     kinds_seen
);
	import ets_pkg::*;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_INT,
		SCAN_DOT,
		SCAN_FRAC,
		SCAN_HALTED
	} scan_state_t;

	typedef enum logic [2:0] {
		BC_SPACE,
		BC_DIGIT,
		BC_LETTER,
		BC_OPERATOR,
		BC_NUL,
		BC_OTHER
	} byte_class_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] length;
		logic        frac;
		err_t        err;
		logic        last;
	} token_rec_t;

	scan_state_t scan;
	logic [31:0] offset;
	logic [31:0] word_begin;
	logic [15:0] word_len;
	logic [39:0] word_head;
	token_rec_t  expected_tokens [$];

	function automatic byte_class_t classify(input logic [7:0] c, output kind_t op);
		byte_class_t cls;
		op = KIND_ERROR;
		cls = BC_OTHER;
		case (c)
			CH_NUL:    cls = BC_NUL;
			CH_ASSIGN: op = KIND_ASSIGN;
			CH_SEMI:   op = KIND_SEMI;
			CH_PLUS:   op = KIND_PLUS;
			CH_MINUS:  op = KIND_MINUS;
			CH_STAR:   op = KIND_STAR;
			CH_SLASH:  op = KIND_SLASH;
			CH_LPAREN: op = KIND_LPAREN;
			CH_RPAREN: op = KIND_RPAREN;
			default:   ;
		endcase
		if (op != KIND_ERROR)
			cls = BC_OPERATOR;
		else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			cls = BC_SPACE;
		else if (c >= "0" && c <= "9")
			cls = BC_DIGIT;
		else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
			cls = BC_LETTER;
		return cls;
	endfunction

	function automatic token_rec_t make_token(input kind_t k, input logic [31:0] s,
			input logic [15:0] l, input logic f, input err_t e);
		token_rec_t t;
		t.kind = k;
		t.start = s;
		t.length = l;
		t.frac = f;
		t.err = e;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic string show(input token_rec_t t);
		return $sformatf("kind %0d start %0d len %0d frac %0b err %0d last %0b",
			t.kind, t.start, t.length, t.frac, t.err, t.last);
	endfunction

	// keywords only match at their exact length
	function automatic kind_t word_kind();
		if (word_len == 16'd3 && word_head == KW_VAR) return KIND_VAR;
		if (word_len == 16'd3 && word_head == KW_INT) return KIND_INT;
		if (word_len == 16'd5 && word_head == KW_FLOAT) return KIND_FLOAT;
		if (word_len == 16'd5 && word_head == KW_PRINT) return KIND_PRINT;
		return KIND_IDENT;
	endfunction

	task automatic grow_word(input logic [7:0] c);
		if (word_len < 16'd5)
			word_head = {word_head[31:0], c};
		if (word_len != '1)
			word_len++;
		offset++;
	endtask

	task automatic open_word(input logic [7:0] c, input scan_state_t next);
		word_begin = offset;
		word_len = 16'd1;
		word_head = {32'd0, c};
		scan = next;
		offset++;
	endtask

	task automatic scan_byte(input logic [7:0] c);
		byte_class_t cls;
		kind_t       op_kind;
		token_rec_t  made [2];
		int          made_n;
		logic        fresh;
		made_n = 0;
		fresh = 1'b1;
		cls = classify(c, op_kind);
		case (scan)
			SCAN_HALTED: fresh = 1'b0;
			SCAN_WORD: begin
				if (cls == BC_LETTER || cls == BC_DIGIT) begin
					grow_word(c);
					fresh = 1'b0;
				end else begin
					made[made_n] = make_token(word_kind(), word_begin, word_len, 1'b0,
						ERR_NONE);
					made_n++;
				end
			end
			SCAN_INT: begin
				if (cls == BC_DIGIT || c == CH_DOT) begin
					grow_word(c);
					if (c == CH_DOT)
						scan = SCAN_DOT;
					fresh = 1'b0;
				end else begin
					made[made_n] = make_token(KIND_NUMBER, word_begin, word_len, 1'b0,
						ERR_NONE);
					made_n++;
				end
			end
			SCAN_DOT: begin
				fresh = 1'b0;
				if (cls == BC_DIGIT) begin
					grow_word(c);
					scan = SCAN_FRAC;
				end else begin
					made[made_n] = make_token(KIND_ERROR, offset, 16'd0, 1'b0, ERR_BAD_DOT);
					made_n++;
					scan = SCAN_HALTED;
				end
			end
			SCAN_FRAC: begin
				if (cls == BC_DIGIT) begin
					grow_word(c);
					fresh = 1'b0;
				end else begin
					made[made_n] = make_token(KIND_NUMBER, word_begin, word_len, 1'b1,
						ERR_NONE);
					made_n++;
				end
			end
			default: ;
		endcase
		if (fresh) begin
			scan = SCAN_IDLE;
			case (cls)
				BC_SPACE:  offset++;
				BC_DIGIT:  open_word(c, SCAN_INT);
				BC_LETTER: open_word(c, SCAN_WORD);
				BC_OPERATOR: begin
					made[made_n] = make_token(op_kind, offset, 16'd1, 1'b0, ERR_NONE);
					made_n++;
					offset++;
				end
				BC_NUL: begin
					made[made_n] = make_token(KIND_END, offset, 16'd0, 1'b0, ERR_NONE);
					made_n++;
					offset = '0;
					word_begin = '0;
					word_len = '0;
					word_head = '0;
				end
				default: begin
					made[made_n] = make_token(KIND_ERROR, offset, 16'd0, 1'b0,
						ERR_UNEXPECT);
					made_n++;
					scan = SCAN_HALTED;
				end
			endcase
		end
		if (made_n > 0)
			made[made_n - 1].last = 1'b1;
		for (int i = 0; i < made_n; i++)
			expected_tokens.push_back(made[i]);
	endtask

	task automatic check_token();
		token_rec_t got;
		token_rec_t want;
		got.kind = token_kind;
		got.start = token_start;
		got.length = token_length;
		got.frac = has_fraction;
		got.err = error_code;
		got.last = last_of_run;
		tokens_checked <= tokens_checked + 1;
		kinds_seen <= kinds_seen | (16'd1 << got.kind);
		if (expected_tokens.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: token with none expected: %s", $realtime, show(got));
			fail_count <= fail_count + 1;
		end else begin
			want = expected_tokens.pop_front();
			if (got !== want) begin
				if (fail_count < 10)
					$display("%0t: token mismatch\n  expected %s\n  actual   %s",
						$realtime, show(want), show(got));
				fail_count <= fail_count + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan = SCAN_IDLE;
			offset = '0;
			word_begin = '0;
			word_len = '0;
			word_head = '0;
			expected_tokens.delete();
			fail_count <= 0;
			pending_count <= 0;
			tokens_checked <= 0;
			kinds_seen <= '0;
		end else begin
			if (out_valid && out_ready)
				check_token();
			if (in_valid && in_ready)
				scan_byte(char_in);
			pending_count <= expected_tokens.size();
		end
	end

endmodule

@@ bench/expression_token_scanner_unit_tb.sv @@
`timescale 1ns / 1ps
module expression_token_scanner_unit_tb;
	import ets_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_in;
	logic        out_valid;
	logic        out_ready;
	kind_t       token_kind;
	logic [31:0] token_start;
	logic [15:0] token_length;
	logic        has_fraction;
	err_t        error_code;
	logic        last_of_run;

	// checker outputs, all updated at the clock edge
	int          fail_count;
	int          pending_count;
	int          tokens_checked;
	logic [15:0] kinds_seen;

	// stimulus bookkeeping
	logic        sender_idles;
	logic        receiver_idles;
	logic        after_token;
	int          bytes_sent;
	string       ending_note;

	// operator bytes in one table for random picks
	logic [7:0] op_chars [8] = '{CH_ASSIGN, CH_SEMI, CH_PLUS, CH_MINUS,
		CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN};

	expression_token_scanner_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.has_fraction(has_fraction),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	// predicts tokens from accepted bytes and compares accepted tokens
	ets_token_checker tok_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.token_start   (token_start),
		.token_length  (token_length),
		.has_fraction  (has_fraction),
		.error_code    (error_code),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.tokens_checked(tokens_checked),
		.kinds_seen    (kinds_seen)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver drops ready about a third of the time while idling is on
	always @(posedge clk)
		out_ready <= !receiver_idles || ($urandom_range(99) >= 33);

	// hard stop in case the handshake hangs
	initial begin
		#10_000_000;
		$display("run timed out with %0d tokens still expected", pending_count);
		$display("FAILED: results differ");
		$finish;
	end

	// one byte request: optional idle gap, then hold valid until taken
	task automatic send_byte(input logic [7:0] b);
		if (sender_idles)
			while ($urandom_range(99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		char_in <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// waits until every predicted token came back, with a bound
	task automatic wait_for_tokens();
		int spins;
		spins = 0;
		do begin
			@(posedge clk);
			spins++;
		end while (pending_count != 0 && spins < 20000);
	endtask

	function automatic logic [7:0] pick_letter();
		return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25)) :
			8'(8'h61 + $urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'(8'h30 + $urandom_range(9));
	endfunction

	// whitespace covers the full 09..0d control range plus blank
	function automatic logic [7:0] pick_space();
		return ($urandom_range(5) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
	endfunction

	// identifiers: exact keywords, keywords with one byte more or less,
	// short random names and the odd long one
	task automatic send_word();
		string kw_text [4];
		string kw;
		int    pick;
		int    n;
		kw_text = '{"var", "int", "float", "print"};
		kw = kw_text[$urandom_range(3)];
		pick = $urandom_range(9);
		if (pick < 3) begin
			send_text(kw);
		end else if (pick < 5) begin
			send_text(kw);
			send_byte($urandom_range(1) ? pick_letter() : pick_digit());
		end else if (pick == 5) begin
			send_text(kw.substr(0, kw.len() - 2));
		end else begin
			n = (pick == 9) ? $urandom_range(6, 14) : $urandom_range(1, 5);
			send_byte(pick_letter());
			repeat (n - 1)
				send_byte(($urandom_range(2) == 0) ? pick_digit() : pick_letter());
		end
	endtask

	// numbers always end on a digit, so a following byte never trips the dot rule
	task automatic send_number();
		repeat ($urandom_range(1, 6))
			send_byte(pick_digit());
		if ($urandom_range(2) == 0) begin
			send_byte(CH_DOT);
			repeat ($urandom_range(1, 4))
				send_byte(pick_digit());
		end
	endtask

	// separators: end of source, an operator, or a short run of whitespace
	task automatic send_gap();
		int r;
		r = $urandom_range(11);
		if (r == 0)
			send_byte(CH_NUL);
		else if (r < 6)
			send_byte(op_chars[$urandom_range(7)]);
		else
			repeat ($urandom_range(1, 3))
				send_byte(pick_space());
	endtask

	// well-formed random source; a number never directly follows another token,
	// so a fraction dot can only land in a digit run
	task automatic random_source(input int until_bytes);
		int r;
		while (bytes_sent < until_bytes) begin
			r = $urandom_range(99);
			if (r < 45) begin
				send_word();
				after_token = 1'b1;
			end else if (r < 85) begin
				if (after_token)
					send_byte(8'h20);
				send_number();
				after_token = 1'b1;
			end
			if ($urandom_range(99) < 85) begin
				send_gap();
				after_token = 1'b0;
			end
		end
	endtask

	initial begin
		logic [7:0] b;
		in_valid <= 1'b0;
		char_in <= 8'h00;
		arst_n <= 1'b0;
		receiver_idles <= 1'b1;
		sender_idles = 1'b1;
		after_token = 1'b0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed source: all keywords and operators, tokens closed both by
		// whitespace and by operators, letter and digit extremes, a fraction,
		// whitespace extremes and the end marker
		send_text("var=int;float\t+print");
		send_byte(8'h0D);
		send_text("-Za9*0.9/(z) ");
		send_byte(CH_NUL);

		// long stretch with both sides always ready
		sender_idles = 1'b0;
		receiver_idles <= 1'b0;
		random_source(400);

		// random stalls on both sides
		sender_idles = 1'b1;
		receiver_idles <= 1'b1;
		random_source(750);

		// sender holds off until the token queue has fully drained
		in_valid <= 1'b0;
		wait_for_tokens();
		random_source(1000);

		// close the source so the error case starts from idle
		send_byte(CH_NUL);

		// the scanner halts on an error, so exactly one ends the run
		if ($urandom_range(1)) begin
			ending_note = "dot without fraction digit";
			send_text(" 7.");
			do b = 8'($urandom_range(255)); while (is_digit(b));
			send_byte(b);
		end else begin
			ending_note = "unexpected byte";
			do
				b = 8'($urandom_range(255));
			while (is_digit(b) || is_letter(b) || is_space(b) || is_operator(b) ||
				b == CH_NUL);
			send_byte(b);
		end

		// halted: everything from here on must be ignored
		repeat (24)
			send_byte(8'($urandom_range(255)));
		in_valid <= 1'b0;

		wait_for_tokens();
		repeat (10) @(posedge clk);

		$display("covered %0d source bytes, %0d tokens checked, kinds seen %b",
			bytes_sent, tokens_checked, kinds_seen);
		$display("stalls on both sides and a full drain; source ended on a %s, then halted",
			ending_note);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (pending_count != 0)
				$display("%0d expected tokens never arrived", pending_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
